// ===== src/ber_tlv_stream_parser_defines.svh =====
// ----------------------------------------------------------------------------
// BER TLV stream parser assertion macros
// Concurrent check wrappers shared by the assertion files.
// ----------------------------------------------------------------------------
`ifndef BER_TLV_STREAM_PARSER_DEFINES_SVH
`define BER_TLV_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, off during reset
`define BTLV_CHK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define BTLV_CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also runs across reset
`define BTLV_CHK_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/btlv_pkg.sv =====
// ----------------------------------------------------------------------------
// BER TLV parser package
// Shared types, codes and sizes of the BER TLV stream parser.
// ----------------------------------------------------------------------------
package btlv_pkg;

   localparam int MAX_DEPTH_DEF     = 16;
   localparam int MAX_LEN_BYTES_DEF = 4;
   localparam int MAX_RESULTS       = 18;
   localparam int TAG_W             = 28;
   localparam int CLEN_W            = 32;
   localparam int NEST_W            = 5;
   localparam int TAG_MAX_GROUPS    = 4;    // 4 x 7 bits = 28 bit tag
   localparam int FQ_DEPTH          = 2;    // power of two
   localparam int OUTQ_DEPTH        = 4;    // power of two

   localparam logic [4:0] TAG_LONG_MARK = 5'h1f;

   typedef enum logic [1:0] {
      EV_HEADER  = 2'd0,
      EV_CONTENT = 2'd1,
      EV_CLOSE   = 2'd2,
      EV_ERROR   = 2'd3
   } ev_type;

   typedef enum logic [3:0] {
      ERR_NONE          = 4'd0,
      ERR_TAG_CUT       = 4'd1,
      ERR_LONG_TAG_CUT  = 4'd2,
      ERR_TAG_LARGE     = 4'd3,
      ERR_LEN_CUT       = 4'd4,
      ERR_LEN_WIDE      = 4'd5,
      ERR_LONG_LEN_CUT  = 4'd6,
      ERR_OVERRUN       = 4'd7,
      ERR_INDEF_PRIM    = 4'd8,
      ERR_TOO_DEEP      = 4'd9
   } err_type;

   typedef enum logic [4:0] {
      PH_TAG0 = 5'b00001,
      PH_TAGN = 5'b00010,
      PH_LEN0 = 5'b00100,
      PH_LENN = 5'b01000,
      PH_BODY = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ST_BYTE = 2'b01,
      ST_UNW  = 2'b10
   } bstate_type;

   // byte as handed from the front queue, with its precomputed classes
   typedef struct packed {
      logic [7:0] data;
      logic       eob;
      logic       zero;
      logic       long_tag;
   } fq_item_type;

   typedef struct packed {
      ev_type              event_kind;
      logic [1:0]          tag_class;
      logic                is_constructed;
      logic [TAG_W-1:0]    tag_value;
      logic [CLEN_W-1:0]   content_length;
      logic                indefinite_length;
      logic [NEST_W-1:0]   nest_level;
      logic [7:0]          data_byte;
      err_type             error_code;
      logic                last_of_run;
   } rsp_type;

endpackage

// ===== src/ber_tlv_stream_parser.sv =====
// ----------------------------------------------------------------------------
// BER TLV stream parser
// Byte-wide ASN.1 BER decoder emitting header, content, close and error events.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  request   in         push / full               req_byte_in, req_end_of_buffer
//  response  out        empty / pop               rsp_* event fields
//
//  One byte per cycle while each byte yields at most one event and the
//  result queue is not full. Further events of a byte (unwind of closing
//  levels) are written in an unwind state that takes no byte: the parser
//  writes one event per cycle and reads one stack entry per cycle. A cut after
//  a tag or length byte with no event of its own also passes through that state.
//  Reset is synchronous; no clearing pass, stack entries are written on push.
//  A full result queue stalls the parser; the input queue takes at most two
//  more bytes and then raises full.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser #(
   parameter int MAX_DEPTH     = btlv_pkg::MAX_DEPTH_DEF,
   parameter int MAX_LEN_BYTES = btlv_pkg::MAX_LEN_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_byte_in,
   input  logic                          req_end_of_buffer,
   // response channel
   output logic                          empty,
   input  logic                          pop,
   output logic [1:0]                    rsp_event_kind,
   output logic [1:0]                    rsp_tag_class,
   output logic                          rsp_is_constructed,
   output logic [btlv_pkg::TAG_W-1:0]    rsp_tag_value,
   output logic [btlv_pkg::CLEN_W-1:0]   rsp_content_length,
   output logic                          rsp_indefinite_length,
   output logic [btlv_pkg::NEST_W-1:0]   rsp_nest_level,
   output logic [7:0]                    rsp_data_byte,
   output logic [3:0]                    rsp_error_code,
   output logic                          rsp_last_of_run
);
   import btlv_pkg::*;

   fq_item_type  item;
   logic         item_valid, item_take;
   logic         outq_full, res_push;
   rsp_type      res, head;

   // front: byte queue, classifies tag and zero bytes on the way in
   btlv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_push    (push),
      .in_full    (full),
      .in_byte    (req_byte_in),
      .in_eob     (req_end_of_buffer),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // back: TLV sequencer and region stack
   btlv_back #(
      .MAX_DEPTH     (MAX_DEPTH),
      .MAX_LEN_BYTES (MAX_LEN_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .outq_full  (outq_full),
      .res_push   (res_push),
      .res        (res)
   );

   // events wait here until the consumer transfers them
   btlv_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (res_push),
      .wr_data  (res),
      .wr_full  (outq_full),
      .rd_pop   (pop),
      .rd_empty (empty),
      .rd_data  (head)
   );

   assign rsp_event_kind        = head.event_kind;
   assign rsp_tag_class         = head.tag_class;
   assign rsp_is_constructed    = head.is_constructed;
   assign rsp_tag_value         = head.tag_value;
   assign rsp_content_length    = head.content_length;
   assign rsp_indefinite_length = head.indefinite_length;
   assign rsp_nest_level        = head.nest_level;
   assign rsp_data_byte         = head.data_byte;
   assign rsp_error_code        = head.error_code;
   assign rsp_last_of_run       = head.last_of_run;

endmodule

// ===== src/btlv_front.sv =====
// ----------------------------------------------------------------------------
// BER TLV parser front
// Input queue; classifies each byte on entry.
// ----------------------------------------------------------------------------
module btlv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_push,
   output logic                  in_full,
   input  logic [7:0]            in_byte,
   input  logic                  in_eob,
   output logic                  item_valid,
   output btlv_pkg::fq_item_type item,
   input  logic                  item_take
);
   import btlv_pkg::*;

   localparam int AW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
   localparam int CW = $clog2(FQ_DEPTH + 1);

   fq_item_type       q_ff [FQ_DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              do_wr, do_rd;
   fq_item_type       new_item;

   assign in_full    = (cnt_ff == CW'(FQ_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = q_ff[rd_ff];
   assign do_wr      = in_push && !in_full;
   assign do_rd      = item_take && item_valid;

   always_comb begin
      new_item.data     = in_byte;
      new_item.eob      = in_eob;
      new_item.zero     = (in_byte == 8'h00);
      new_item.long_tag = (in_byte[4:0] == TAG_LONG_MARK);
      wr_in  = do_wr ? wr_ff + AW'(1) : wr_ff;
      rd_in  = do_rd ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + CW'(do_wr) - CW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ff] <= new_item;
      end
   end

endmodule

// ===== src/btlv_back.sv =====
// ----------------------------------------------------------------------------
// BER TLV parser back
// Header/content sequencer with the stack of open regions and close unwind.
// ----------------------------------------------------------------------------
module btlv_back #(
   parameter int MAX_DEPTH     = btlv_pkg::MAX_DEPTH_DEF,
   parameter int MAX_LEN_BYTES = btlv_pkg::MAX_LEN_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  btlv_pkg::fq_item_type item,
   output logic                  item_take,
   input  logic                  outq_full,
   output logic                  res_push,
   output btlv_pkg::rsp_type     res
);
   import btlv_pkg::*;

   localparam int LEN_W = 8 * MAX_LEN_BYTES;
   localparam int OFF_W = LEN_W + 1;
   localparam int SP_W  = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   // innermost definite limit of the current level
   function automatic logic lim_eq(input logic lv, input logic [OFF_W-1:0] lim,
                                   input logic [OFF_W-1:0] off, input logic eob);
      lim_eq = lv ? (lim == off) : eob;
   endfunction

   function automatic logic lim_gt(input logic lv, input logic [OFF_W-1:0] lim,
                                   input logic [OFF_W:0] x,
                                   input logic [OFF_W-1:0] off, input logic eob);
      lim_gt = lv ? (x > {1'b0, lim}) : (eob && (x > {1'b0, off}));
   endfunction

   bstate_type          state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic                err_ff, err_in;
   logic [OFF_W-1:0]    offset_ff, offset_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [2:0]          shift_ff, shift_in;
   logic [2:0]          hcf_ff, hcf_in;
   logic                zero_ff, zero_in;
   logic [LEN_W-1:0]    lacc_ff, lacc_in;
   logic [3:0]          left_ff, left_in;
   logic [LEN_W-1:0]    cl_ff, cl_in;
   logic [SP_W-1:0]     sp_ff, sp_in;
   logic                eob_ff, eob_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   // top-of-stack view: open flag, limit, outermost definite stop
   logic                cur_open_ff, cur_open_in;
   logic                cur_lv_ff, cur_lv_in;
   logic [OFF_W-1:0]    cur_lim_ff, cur_lim_in;
   logic                cur_ov_ff, cur_ov_in;
   logic [OFF_W-1:0]    cur_outer_ff, cur_outer_in;

   // saved views of the levels below
   logic                ent_open_ff  [MAX_DEPTH];
   logic                ent_lv_ff    [MAX_DEPTH];
   logic [OFF_W-1:0]    ent_lim_ff   [MAX_DEPTH];
   logic                ent_ov_ff    [MAX_DEPTH];
   logic [OFF_W-1:0]    ent_outer_ff [MAX_DEPTH];
   logic                ent_we;

   logic [7:0]          b;
   logic                e;
   logic [OFF_W-1:0]    off1;
   logic [6:0]          nlen;
   logic [OFF_W:0]      n_x, stop_x;
   logic                hdr_go, hdr_indef, hdr_eoc;
   logic [LEN_W-1:0]    hdr_len;
   logic                emit, more, fail_now, fin, fin_eob, do_pop;
   logic [SP_W-1:0]     sp_m1;
   logic [IDX_W-1:0]    rd_idx, wr_idx;
   logic [CNT_W-1:0]    cnt_cur;
   rsp_type             r;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      err_in       = err_ff;
      offset_in    = offset_ff;
      tag_in       = tag_ff;
      shift_in     = shift_ff;
      hcf_in       = hcf_ff;
      zero_in      = zero_ff;
      lacc_in      = lacc_ff;
      left_in      = left_ff;
      cl_in        = cl_ff;
      sp_in        = sp_ff;
      eob_in       = eob_ff;
      cnt_in       = cnt_ff;
      cur_open_in  = cur_open_ff;
      cur_lv_in    = cur_lv_ff;
      cur_lim_in   = cur_lim_ff;
      cur_ov_in    = cur_ov_ff;
      cur_outer_in = cur_outer_ff;
      ent_we       = 1'b0;

      sp_m1   = sp_ff - SP_W'(1);
      rd_idx  = sp_m1[IDX_W-1:0];
      wr_idx  = sp_ff[IDX_W-1:0];
      b       = item.data;
      e       = item.eob;
      off1    = offset_ff + OFF_W'(1);
      nlen    = b[6:0];
      n_x     = {1'b0, off1} + (OFF_W+1)'(nlen);
      stop_x  = '0;
      hdr_go    = 1'b0;
      hdr_indef = 1'b0;
      hdr_eoc   = 1'b0;
      hdr_len   = '0;
      r        = '0;
      emit     = 1'b0;
      more     = 1'b0;
      fail_now = 1'b0;
      fin      = 1'b0;
      fin_eob  = 1'b0;
      do_pop   = 1'b0;
      item_take = 1'b0;
      cnt_cur  = (state_ff == ST_UNW) ? cnt_ff : '0;

      case (state_ff)
         ST_BYTE: begin
            if (item_valid && !outq_full) begin
               item_take = 1'b1;
               eob_in    = e;
               fin_eob   = e;
               cnt_in    = '0;
               if (err_ff) begin
                  fin = 1'b1;
               end else if (e && ((cur_ov_ff && (cur_outer_ff > off1)) ||
                                  (phase_ff == PH_BODY && cl_ff > LEN_W'(1)))) begin
                  // buffer ends inside an open definite region
                  emit = 1'b1;
                  r.event_kind = EV_ERROR;
                  r.nest_level = NEST_W'(sp_ff);
                  r.error_code = ERR_OVERRUN;
                  err_in = 1'b1;
                  fin    = 1'b1;
               end else begin
                  offset_in = off1;
                  case (phase_ff)
                     PH_TAG0: begin
                        hcf_in  = b[7:5];
                        zero_in = item.zero;
                        if (!item.long_tag) begin
                           tag_in   = TAG_W'(b[4:0]);
                           phase_in = PH_LEN0;
                        end else begin
                           tag_in   = '0;
                           shift_in = '0;
                           phase_in = PH_TAGN;
                        end
                     end
                     PH_TAGN: begin
                        tag_in   = {tag_ff[TAG_W-8:0], b[6:0]};
                        shift_in = shift_ff + 3'd1;
                        if (shift_in > 3'(TAG_MAX_GROUPS)) begin
                           fail_now = 1'b1;
                           r.error_code = ERR_TAG_LARGE;
                        end else if (!b[7]) begin
                           phase_in = PH_LEN0;
                        end
                     end
                     PH_LEN0: begin
                        if (!b[7]) begin
                           hdr_go  = 1'b1;
                           hdr_len = LEN_W'(b);
                           hdr_eoc = zero_ff && item.zero;
                        end else if (nlen == 7'd0) begin
                           hdr_go    = 1'b1;
                           hdr_indef = 1'b1;
                        end else if (nlen > 7'(MAX_LEN_BYTES)) begin
                           fail_now = 1'b1;
                           r.error_code = ERR_LEN_WIDE;
                        end else if (lim_gt(cur_lv_ff, cur_lim_ff, n_x, off1, e)) begin
                           fail_now = 1'b1;
                           r.error_code = ERR_LONG_LEN_CUT;
                        end else begin
                           lacc_in  = '0;
                           left_in  = 4'(nlen);
                           phase_in = PH_LENN;
                        end
                     end
                     PH_LENN: begin
                        lacc_in = (lacc_ff << 8) | LEN_W'(b);
                        left_in = (left_ff != 4'd0) ? left_ff - 4'd1 : left_ff;
                        if (left_in == 4'd0) begin
                           hdr_go  = 1'b1;
                           hdr_len = lacc_in;
                        end
                     end
                     PH_BODY: begin
                        emit = 1'b1;
                        r.event_kind = EV_CONTENT;
                        r.nest_level = NEST_W'(sp_ff);
                        r.data_byte  = b;
                        cl_in = (cl_ff != '0) ? cl_ff - LEN_W'(1) : cl_ff;
                        if (cl_in == '0) begin
                           phase_in = PH_TAG0;
                        end
                     end
                     default: begin
                        phase_in = PH_TAG0;
                     end
                  endcase

                  if (hdr_go) begin
                     phase_in = PH_TAG0;
                     stop_x   = {1'b0, off1} + (OFF_W+1)'(hdr_len);
                     if (hdr_eoc && sp_ff != '0 && cur_open_ff) begin
                        // end-of-contents closes the indefinite level
                        emit = 1'b1;
                        r.event_kind        = EV_CLOSE;
                        r.indefinite_length = 1'b1;
                        r.nest_level        = NEST_W'(sp_m1);
                        do_pop = 1'b1;
                     end else if (!hdr_indef &&
                                  lim_gt(cur_lv_ff, cur_lim_ff, stop_x, off1, e)) begin
                        fail_now = 1'b1;
                        r.error_code = ERR_OVERRUN;
                     end else if (hcf_ff[0]) begin
                        if (sp_ff >= SP_W'(MAX_DEPTH)) begin
                           fail_now = 1'b1;
                           r.error_code = ERR_TOO_DEEP;
                        end else begin
                           emit = 1'b1;
                           r.event_kind        = EV_HEADER;
                           r.tag_class         = hcf_ff[2:1];
                           r.is_constructed    = 1'b1;
                           r.tag_value         = tag_ff;
                           r.content_length    = hdr_indef ? '0 : CLEN_W'(hdr_len);
                           r.indefinite_length = hdr_indef;
                           r.nest_level        = NEST_W'(sp_ff);
                           ent_we       = 1'b1;
                           sp_in        = sp_ff + SP_W'(1);
                           cur_open_in  = hdr_indef;
                           if (!hdr_indef) begin
                              cur_lv_in  = 1'b1;
                              cur_lim_in = stop_x[OFF_W-1:0];
                              cur_ov_in  = 1'b1;
                              if (!cur_ov_ff) begin
                                 cur_outer_in = stop_x[OFF_W-1:0];
                              end
                           end
                        end
                     end else if (hdr_indef) begin
                        fail_now = 1'b1;
                        r.error_code = ERR_INDEF_PRIM;
                     end else begin
                        emit = 1'b1;
                        r.event_kind     = EV_HEADER;
                        r.tag_class      = hcf_ff[2:1];
                        r.tag_value      = tag_ff;
                        r.content_length = CLEN_W'(hdr_len);
                        r.nest_level     = NEST_W'(sp_ff);
                        if (hdr_len != '0) begin
                           cl_in    = hdr_len;
                           phase_in = PH_BODY;
                        end
                     end
                  end

                  if (do_pop) begin
                     sp_in        = sp_m1;
                     cur_open_in  = ent_open_ff[rd_idx];
                     cur_lv_in    = ent_lv_ff[rd_idx];
                     cur_lim_in   = ent_lim_ff[rd_idx];
                     cur_ov_in    = ent_ov_ff[rd_idx];
                     cur_outer_in = ent_outer_ff[rd_idx];
                  end

                  if (fail_now) begin
                     emit = 1'b1;
                     r.event_kind = EV_ERROR;
                     r.nest_level = NEST_W'(sp_ff);
                     err_in = 1'b1;
                     fin    = 1'b1;
                  end else if (lim_eq(cur_lv_in, cur_lim_in, off1, e) &&
                               (phase_in != PH_TAG0 || sp_in != '0)) begin
                     more     = emit;
                     cnt_in   = emit ? CNT_W'(1) : '0;
                     state_in = ST_UNW;
                  end else begin
                     fin = 1'b1;
                  end
               end
            end
         end
         ST_UNW: begin
            if (!outq_full) begin
               fin_eob = eob_ff;
               emit    = 1'b1;
               if (cnt_ff < CNT_W'(MAX_RESULTS)) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (phase_ff != PH_TAG0) begin
                  // region or buffer ended inside an element
                  r.event_kind = EV_ERROR;
                  r.nest_level = NEST_W'(sp_ff);
                  case (phase_ff)
                     PH_TAGN: r.error_code = ERR_LONG_TAG_CUT;
                     PH_LEN0: r.error_code = ERR_LEN_CUT;
                     PH_LENN: r.error_code = ERR_LONG_LEN_CUT;
                     default: r.error_code = ERR_OVERRUN;
                  endcase
                  err_in = 1'b1;
                  fin    = 1'b1;
               end else begin
                  r.event_kind        = EV_CLOSE;
                  r.indefinite_length = cur_open_ff;
                  r.nest_level        = NEST_W'(sp_m1);
                  sp_in        = sp_m1;
                  cur_open_in  = ent_open_ff[rd_idx];
                  cur_lv_in    = ent_lv_ff[rd_idx];
                  cur_lim_in   = ent_lim_ff[rd_idx];
                  cur_ov_in    = ent_ov_ff[rd_idx];
                  cur_outer_in = ent_outer_ff[rd_idx];
                  more = (sp_m1 != '0) &&
                         lim_eq(ent_lv_ff[rd_idx], ent_lim_ff[rd_idx], offset_ff, eob_ff);
                  if (!more) begin
                     fin = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_BYTE;
         end
      endcase

      if (fin) begin
         state_in = ST_BYTE;
         if (fin_eob) begin
            phase_in     = PH_TAG0;
            err_in       = 1'b0;
            offset_in    = '0;
            tag_in       = '0;
            shift_in     = '0;
            hcf_in       = '0;
            zero_in      = 1'b0;
            lacc_in      = '0;
            left_in      = '0;
            cl_in        = '0;
            sp_in        = '0;
            cur_open_in  = 1'b0;
            cur_lv_in    = 1'b0;
            cur_lim_in   = '0;
            cur_ov_in    = 1'b0;
            cur_outer_in = '0;
         end
      end

      r.last_of_run = !more || (cnt_cur == CNT_W'(MAX_RESULTS - 1));
      res      = r;
      res_push = emit && (cnt_cur < CNT_W'(MAX_RESULTS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BYTE;
         phase_ff     <= PH_TAG0;
         err_ff       <= 1'b0;
         offset_ff    <= '0;
         tag_ff       <= '0;
         shift_ff     <= '0;
         hcf_ff       <= '0;
         zero_ff      <= 1'b0;
         lacc_ff      <= '0;
         left_ff      <= '0;
         cl_ff        <= '0;
         sp_ff        <= '0;
         eob_ff       <= 1'b0;
         cnt_ff       <= '0;
         cur_open_ff  <= 1'b0;
         cur_lv_ff    <= 1'b0;
         cur_lim_ff   <= '0;
         cur_ov_ff    <= 1'b0;
         cur_outer_ff <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         offset_ff    <= offset_in;
         tag_ff       <= tag_in;
         shift_ff     <= shift_in;
         hcf_ff       <= hcf_in;
         zero_ff      <= zero_in;
         lacc_ff      <= lacc_in;
         left_ff      <= left_in;
         cl_ff        <= cl_in;
         sp_ff        <= sp_in;
         eob_ff       <= eob_in;
         cnt_ff       <= cnt_in;
         cur_open_ff  <= cur_open_in;
         cur_lv_ff    <= cur_lv_in;
         cur_lim_ff   <= cur_lim_in;
         cur_ov_ff    <= cur_ov_in;
         cur_outer_ff <= cur_outer_in;
      end
   end

   // stack write saves the view of the level being entered from
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_open_ff[wr_idx]  <= cur_open_ff;
         ent_lv_ff[wr_idx]    <= cur_lv_ff;
         ent_lim_ff[wr_idx]   <= cur_lim_ff;
         ent_ov_ff[wr_idx]    <= cur_ov_ff;
         ent_outer_ff[wr_idx] <= cur_outer_ff;
      end
   end

endmodule

// ===== src/btlv_outq.sv =====
// ----------------------------------------------------------------------------
// BER TLV parser result queue
// Small FIFO of result events toward the consumer.
// ----------------------------------------------------------------------------
module btlv_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_push,
   input  btlv_pkg::rsp_type wr_data,
   output logic              wr_full,
   input  logic              rd_pop,
   output logic              rd_empty,
   output btlv_pkg::rsp_type rd_data
);
   import btlv_pkg::*;

   localparam int AW = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
   localparam int CW = $clog2(OUTQ_DEPTH + 1);

   rsp_type        q_ff [OUTQ_DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           do_wr, do_rd;

   assign wr_full  = (cnt_ff == CW'(OUTQ_DEPTH));
   assign rd_empty = (cnt_ff == '0);
   assign rd_data  = q_ff[rd_ff];
   assign do_wr    = wr_push && !wr_full;
   assign do_rd    = rd_pop && !rd_empty;

   always_comb begin
      wr_in  = do_wr ? wr_ff + AW'(1) : wr_ff;
      rd_in  = do_rd ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + CW'(do_wr) - CW'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ff] <= wr_data;
      end
   end

endmodule

// ===== src/btlv_checker.sv =====
// ----------------------------------------------------------------------------
// BER TLV parser checker
// Port-level checks on the event stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ber_tlv_stream_parser_defines.svh"

module btlv_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          push,
   input logic                          full,
   input logic [7:0]                    req_byte_in,
   input logic                          req_end_of_buffer,
   input logic                          empty,
   input logic                          pop,
   input logic [1:0]                    rsp_event_kind,
   input logic [1:0]                    rsp_tag_class,
   input logic                          rsp_is_constructed,
   input logic [btlv_pkg::TAG_W-1:0]    rsp_tag_value,
   input logic [btlv_pkg::CLEN_W-1:0]   rsp_content_length,
   input logic                          rsp_indefinite_length,
   input logic [btlv_pkg::NEST_W-1:0]   rsp_nest_level,
   input logic [7:0]                    rsp_data_byte,
   input logic [3:0]                    rsp_error_code,
   input logic                          rsp_last_of_run
);
   import btlv_pkg::*;

   logic        head_wait;
   logic [9:0]  head_key;
   logic        err_head, err_ok;
   logic        indef_head, indef_ok;
   logic        content_head, content_ok;

   assign head_wait    = !empty && !pop;
   assign head_key     = {rsp_event_kind, rsp_data_byte};
   assign err_head     = !empty && (rsp_event_kind == EV_ERROR);
   assign err_ok       = (rsp_error_code != ERR_NONE) && rsp_last_of_run;
   assign indef_head   = !empty && (rsp_event_kind == EV_HEADER) && rsp_indefinite_length;
   assign indef_ok     = (rsp_content_length == '0) && rsp_is_constructed;
   assign content_head = !empty && (rsp_event_kind == EV_CONTENT);
   assign content_ok   = (rsp_tag_value == '0) && (rsp_error_code == ERR_NONE) &&
                         !rsp_is_constructed;

   `BTLV_CHK_RST(a_reset_idle, reset, empty && !full, "queues not empty after reset")
   `BTLV_CHK_NEXT(a_head_hold, head_wait, !empty && $stable(head_key), "waiting event changed")
   `BTLV_CHK(a_err_code, err_head, err_ok, "error event without code or not last")
   `BTLV_CHK(a_indef_len, indef_head, indef_ok, "indefinite header malformed")
   `BTLV_CHK(a_content_clean, content_head, content_ok, "content event carries header fields")

endmodule

bind ber_tlv_stream_parser btlv_checker u_btlv_checker (.*);
